FILE: src/cpu_load_moving_average_defines.svh
// Assertion macros shared by the CPU load moving average RTL.
// Every macro samples on clock and is disabled while reset is high.
`ifndef CPU_LOAD_MOVING_AVERAGE_DEFINES_SVH
`define CPU_LOAD_MOVING_AVERAGE_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define CLMA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// The consequence must hold in the cycle after the cause, outside reset.
`define CLMA_ASSERT_NEXT(label, cause, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cause) |=> (conseq)) \
      else $error(msg);

`endif

FILE: src/clma_pkg.sv
// Shared widths, constants and types of the CPU load moving average block.
// No dependencies; every other file of the block but the assertion macro header imports this package.
`default_nettype none

package clma_pkg;

   localparam int DELTA_W = 64;          // counter and delta width
   localparam int DEN_W   = DELTA_W + 1; // kernel plus user delta
   localparam int UNIT_W  = DEN_W + 4;   // remainder times ten fits here
   localparam int LOAD_W  = 14;

   localparam logic [LOAD_W-1:0] LOAD_FULL_SCALE = LOAD_W'(10000);

   localparam int RADIX   = 10;
   localparam int DIGIT_W = 4;
   localparam int DIGITS  = 4;
   localparam int DCNT_W  = $clog2(DIGITS);

   localparam int DEFAULT_SHORT_WINDOW = 5;
   localparam int DEFAULT_MID_WINDOW   = 10;
   localparam int DEFAULT_LONG_WINDOW  = 15;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

endpackage

`default_nettype wire

FILE: src/clma_req_if.sv
// Input channel of the CPU load moving average block: one counter sample per item.
// Depends on clma_pkg for the counter width.
`default_nettype none

interface clma_req_if import clma_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [DELTA_W-1:0] idle_time;
   logic [DELTA_W-1:0] kernel_time;
   logic [DELTA_W-1:0] user_time;

   modport source (output valid, output idle_time, output kernel_time, output user_time,
                   input ready);
   modport sink (input valid, input idle_time, input kernel_time, input user_time,
                 output ready);
endinterface

`default_nettype wire

FILE: src/clma_rsp_if.sv
// Result channel of the CPU load moving average block: current load and three means.
// Depends on clma_pkg for the load width.
`default_nettype none

interface clma_rsp_if import clma_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [LOAD_W-1:0] load_now;
   logic              load_now_valid;
   logic [LOAD_W-1:0] mean_short;
   logic              mean_short_valid;
   logic [LOAD_W-1:0] mean_mid;
   logic              mean_mid_valid;
   logic [LOAD_W-1:0] mean_long;
   logic              mean_long_valid;

   modport source (output valid, output load_now, output load_now_valid,
                   output mean_short, output mean_short_valid,
                   output mean_mid, output mean_mid_valid,
                   output mean_long, output mean_long_valid,
                   input ready);
   modport sink (input valid, input load_now, input load_now_valid,
                 input mean_short, input mean_short_valid,
                 input mean_mid, input mean_mid_valid,
                 input mean_long, input mean_long_valid,
                 output ready);
endinterface

`default_nettype wire

FILE: src/clma_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on clma_pkg only for its default sizes.
`default_nettype none

module clma_ram import clma_pkg::*; #(
   parameter int WIDTH = LOAD_W,
   parameter int DEPTH = DEFAULT_LONG_WINDOW
) (
   input  wire logic                                         clock,
   input  wire logic                                         wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  wire logic [WIDTH-1:0]                             wr_data,
   input  wire logic                                         rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output      logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/clma_addsub.sv
// Shared adder/subtractor used by the sequencer for deltas, sums and the divider.
// Depends on clma_pkg for the operand width and the operation type.
`default_nettype none

module clma_addsub import clma_pkg::*; (
   input  wire alu_op_type        op,
   input  wire logic [UNIT_W-1:0] opa,
   input  wire logic [UNIT_W-1:0] opb,
   output      logic [UNIT_W-1:0] result,
   output      logic              carry
);

   logic              is_sub;
   logic [UNIT_W-1:0] opb_eff;
   logic [UNIT_W:0]   full;

   assign is_sub  = (op == ALU_SUB);
   assign opb_eff = is_sub ? ~opb : opb;
   // For a subtraction the carry out is set exactly when opa >= opb.
   assign full    = {1'b0, opa} + {1'b0, opb_eff} + (UNIT_W + 1)'(is_sub);
   assign result  = full[UNIT_W-1:0];
   assign carry   = full[UNIT_W];

endmodule

`default_nettype wire

FILE: src/cpu_load_moving_average.sv
// CPU load moving average. Each item carries the cumulative idle, kernel (idle included)
// and user time counters; the first item after reset only primes the stored counters and
// returns an all-zero result. Later items give the load since the previous item,
// floor(10000 * (kernel + user - idle) / (kernel + user)) in hundredths of a percent (zero
// when the denominator is zero or the busy time is negative), plus the truncated means of
// the last SHORT_WINDOW, MID_WINDOW and LONG_WINDOW loads, each flagged valid once that
// many loads are stored. One item is processed at a time: a priming item goes from
// acceptance straight to the done state; a load item passes the delta steps, the decimal
// long division on the single shared 69-bit adder (four digits, each found by repeated
// subtraction) and the pass over the load ring, one entry read per cycle from its RAM,
// before the block is ready again. The result sits in an output register, so a waiting
// result does not hold up the next item until it completes. Depends on clma_pkg, the
// channel interfaces, clma_addsub and clma_ram.
`default_nettype none

`include "cpu_load_moving_average_defines.svh"

module cpu_load_moving_average import clma_pkg::*; #(
   parameter int SHORT_WINDOW = DEFAULT_SHORT_WINDOW,
   parameter int MID_WINDOW   = DEFAULT_MID_WINDOW,
   parameter int LONG_WINDOW  = DEFAULT_LONG_WINDOW
) (
   input wire logic    clock,
   input wire logic    reset,
   clma_req_if.sink    req_ch,
   clma_rsp_if.source  rsp_ch
);

   localparam int PTR_W   = $clog2(LONG_WINDOW);
   localparam int CNT_W   = $clog2(LONG_WINDOW + 1);
   localparam int SUM_W   = $clog2(LONG_WINDOW * 10000 + 1);
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;

   // Means use a multiply by a rounded-up reciprocal; exact for every SUM_W-bit sum.
   localparam int SHIFT_SHORT = SUM_W + $clog2(SHORT_WINDOW);
   localparam int SHIFT_MID   = SUM_W + $clog2(MID_WINDOW);
   localparam int SHIFT_LONG  = SUM_W + $clog2(LONG_WINDOW);
   localparam logic [RECIP_W-1:0] RECIP_SHORT =
      RECIP_W'(((64'd1 << SHIFT_SHORT) + SHORT_WINDOW - 1) / SHORT_WINDOW);
   localparam logic [RECIP_W-1:0] RECIP_MID =
      RECIP_W'(((64'd1 << SHIFT_MID) + MID_WINDOW - 1) / MID_WINDOW);
   localparam logic [RECIP_W-1:0] RECIP_LONG =
      RECIP_W'(((64'd1 << SHIFT_LONG) + LONG_WINDOW - 1) / LONG_WINDOW);

   localparam bit SHORT_FITS = (SHORT_WINDOW <= LONG_WINDOW);
   localparam bit MID_FITS   = (MID_WINDOW <= LONG_WINDOW);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIDLE,
      S_DKERN,
      S_DUSER,
      S_DENOM,
      S_BUSY,
      S_MUL10,
      S_DIGIT,
      S_WRITE,
      S_SCAN,
      S_MEAN,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      MSEL_SHORT,
      MSEL_MID,
      MSEL_LONG,
      MSEL_END
   } mean_sel_type;

   state_type          state_ff;
   logic               primed_ff;
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [CNT_W-1:0]   stored_cnt_ff;

   logic [DELTA_W-1:0] prior_idle_ff;
   logic [DELTA_W-1:0] prior_kern_ff;
   logic [DELTA_W-1:0] prior_user_ff;
   logic [DELTA_W-1:0] smp_idle_ff;     // sample, then delta
   logic [DELTA_W-1:0] smp_kern_ff;
   logic [DELTA_W-1:0] smp_user_ff;
   logic [DEN_W-1:0]   denom_ff;
   logic [UNIT_W-1:0]  rem_ff;
   logic [LOAD_W-1:0]  quot_ff;
   logic [DIGIT_W-1:0] digit_ff;
   logic [DCNT_W-1:0]  dcnt_ff;
   logic [LOAD_W-1:0]  load_ff;
   logic               load_vld_ff;

   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   scan_cnt_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [SUM_W-1:0]   sum_short_ff;
   logic [SUM_W-1:0]   sum_mid_ff;
   logic [SUM_W-1:0]   sum_long_ff;
   mean_sel_type       mean_idx_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [LOAD_W-1:0]  mean_short_ff;
   logic [LOAD_W-1:0]  mean_mid_ff;
   logic [LOAD_W-1:0]  mean_long_ff;

   logic               rsp_valid_ff;
   logic [LOAD_W-1:0]  rsp_load_ff;
   logic               rsp_load_vld_ff;
   logic [LOAD_W-1:0]  rsp_short_ff;
   logic               rsp_short_vld_ff;
   logic [LOAD_W-1:0]  rsp_mid_ff;
   logic               rsp_mid_vld_ff;
   logic [LOAD_W-1:0]  rsp_long_ff;
   logic               rsp_long_vld_ff;

   alu_op_type         alu_op;
   logic [UNIT_W-1:0]  alu_a;
   logic [UNIT_W-1:0]  alu_b;
   logic [UNIT_W-1:0]  alu_sum;
   logic               alu_carry;

   logic [LOAD_W-1:0]  quot_in;
   logic [SUM_W-1:0]   sum_in;
   logic               scan_take;
   logic               ram_rd_en;
   logic [LOAD_W-1:0]  ram_rd_data;
   logic [SUM_W-1:0]   mul_a;
   logic [RECIP_W-1:0] mul_b;
   logic [PROD_W-1:0]  mul_prod;
   logic               vld_short;
   logic               vld_mid;
   logic               vld_long;

   clma_addsub u_alu (
      .op     (alu_op),
      .opa    (alu_a),
      .opb    (alu_b),
      .result (alu_sum),
      .carry  (alu_carry)
   );

   clma_ram #(
      .WIDTH (LOAD_W),
      .DEPTH (LONG_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (state_ff == S_WRITE),
      .wr_addr (wr_ptr_ff),
      .wr_data (load_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   // Operand selection for the shared adder.
   always_comb begin
      alu_op = ALU_SUB;
      alu_a  = '0;
      alu_b  = '0;
      unique case (state_ff)
         S_DIDLE: begin
            alu_a = UNIT_W'(smp_idle_ff);
            alu_b = UNIT_W'(prior_idle_ff);
         end
         S_DKERN: begin
            alu_a = UNIT_W'(smp_kern_ff);
            alu_b = UNIT_W'(prior_kern_ff);
         end
         S_DUSER: begin
            alu_a = UNIT_W'(smp_user_ff);
            alu_b = UNIT_W'(prior_user_ff);
         end
         S_DENOM: begin
            alu_op = ALU_ADD;
            alu_a  = UNIT_W'(smp_kern_ff);
            alu_b  = UNIT_W'(smp_user_ff);
         end
         S_BUSY: begin
            alu_a = UNIT_W'(denom_ff);
            alu_b = UNIT_W'(smp_idle_ff);
         end
         S_MUL10: begin
            alu_op = ALU_ADD;
            alu_a  = rem_ff << 3;
            alu_b  = rem_ff << 1;
         end
         S_DIGIT: begin
            alu_a = rem_ff;
            alu_b = UNIT_W'(denom_ff);
         end
         default: begin
         end
      endcase
   end

   assign quot_in = LOAD_W'((quot_ff << 3) + (quot_ff << 1) + LOAD_W'(digit_ff));

   // Ring pass: the entry read at count n-1 arrives at count n, newest first.
   assign ram_rd_en = (state_ff == S_SCAN) && (scan_cnt_ff < CNT_W'(LONG_WINDOW));
   assign scan_take = (scan_cnt_ff != '0) && (scan_cnt_ff <= stored_cnt_ff);
   assign sum_in    = scan_take ? sum_ff + SUM_W'(ram_rd_data) : sum_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (mean_idx_ff)
         MSEL_SHORT: begin
            mul_a = sum_short_ff;
            mul_b = RECIP_SHORT;
         end
         MSEL_MID: begin
            mul_a = sum_mid_ff;
            mul_b = RECIP_MID;
         end
         MSEL_LONG: begin
            mul_a = sum_long_ff;
            mul_b = RECIP_LONG;
         end
         MSEL_END: begin
         end
      endcase
   end

   assign mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);

   assign vld_short = SHORT_FITS && (int'(stored_cnt_ff) >= SHORT_WINDOW);
   assign vld_mid   = MID_FITS && (int'(stored_cnt_ff) >= MID_WINDOW);
   assign vld_long  = (int'(stored_cnt_ff) >= LONG_WINDOW);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         primed_ff     <= 1'b0;
         wr_ptr_ff     <= '0;
         stored_cnt_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // In the done state the output register is refilled below instead.
         if (rsp_ch.valid && rsp_ch.ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  smp_idle_ff <= req_ch.idle_time;
                  smp_kern_ff <= req_ch.kernel_time;
                  smp_user_ff <= req_ch.user_time;
                  load_ff     <= '0;
                  load_vld_ff <= 1'b0;
                  if (primed_ff) begin
                     state_ff <= S_DIDLE;
                  end else begin
                     prior_idle_ff <= req_ch.idle_time;
                     prior_kern_ff <= req_ch.kernel_time;
                     prior_user_ff <= req_ch.user_time;
                     primed_ff     <= 1'b1;
                     state_ff      <= S_DONE;
                  end
               end
            end
            S_DIDLE: begin
               prior_idle_ff <= smp_idle_ff;
               smp_idle_ff   <= alu_sum[DELTA_W-1:0];
               state_ff      <= S_DKERN;
            end
            S_DKERN: begin
               prior_kern_ff <= smp_kern_ff;
               smp_kern_ff   <= alu_sum[DELTA_W-1:0];
               state_ff      <= S_DUSER;
            end
            S_DUSER: begin
               prior_user_ff <= smp_user_ff;
               smp_user_ff   <= alu_sum[DELTA_W-1:0];
               state_ff      <= S_DENOM;
            end
            S_DENOM: begin
               denom_ff <= alu_sum[DEN_W-1:0];
               state_ff <= S_BUSY;
            end
            S_BUSY: begin
               load_vld_ff <= 1'b1;
               // The carry is clear when the idle delta exceeds kernel plus user.
               priority if ((denom_ff == '0) || !alu_carry) begin
                  load_ff  <= '0;
                  state_ff <= S_WRITE;
               end else if (smp_idle_ff == '0) begin
                  load_ff  <= LOAD_FULL_SCALE;
                  state_ff <= S_WRITE;
               end else begin
                  rem_ff   <= alu_sum;
                  quot_ff  <= '0;
                  dcnt_ff  <= '0;
                  state_ff <= S_MUL10;
               end
            end
            S_MUL10: begin
               rem_ff   <= alu_sum;
               digit_ff <= '0;
               state_ff <= S_DIGIT;
            end
            S_DIGIT: begin
               if (alu_carry) begin
                  rem_ff   <= alu_sum;
                  digit_ff <= digit_ff + DIGIT_W'(1);
               end else begin
                  quot_ff <= quot_in;
                  if (dcnt_ff == DCNT_W'(DIGITS - 1)) begin
                     load_ff  <= quot_in;
                     state_ff <= S_WRITE;
                  end else begin
                     dcnt_ff  <= dcnt_ff + DCNT_W'(1);
                     state_ff <= S_MUL10;
                  end
               end
            end
            S_WRITE: begin
               wr_ptr_ff <= (wr_ptr_ff == PTR_W'(LONG_WINDOW - 1)) ? '0
                                                                   : wr_ptr_ff + PTR_W'(1);
               if (stored_cnt_ff < CNT_W'(LONG_WINDOW)) begin
                  stored_cnt_ff <= stored_cnt_ff + CNT_W'(1);
               end
               rd_ptr_ff   <= wr_ptr_ff;
               scan_cnt_ff <= '0;
               sum_ff      <= '0;
               state_ff    <= S_SCAN;
            end
            S_SCAN: begin
               sum_ff <= sum_in;
               if (int'(scan_cnt_ff) == SHORT_WINDOW) begin
                  sum_short_ff <= sum_in;
               end
               if (int'(scan_cnt_ff) == MID_WINDOW) begin
                  sum_mid_ff <= sum_in;
               end
               if (int'(scan_cnt_ff) == LONG_WINDOW) begin
                  sum_long_ff <= sum_in;
               end
               if (ram_rd_en) begin
                  rd_ptr_ff <= (rd_ptr_ff == '0) ? PTR_W'(LONG_WINDOW - 1)
                                                 : rd_ptr_ff - PTR_W'(1);
               end
               if (scan_cnt_ff == CNT_W'(LONG_WINDOW)) begin
                  mean_idx_ff <= MSEL_SHORT;
                  state_ff    <= S_MEAN;
               end else begin
                  scan_cnt_ff <= scan_cnt_ff + CNT_W'(1);
               end
            end
            S_MEAN: begin
               // The product of the previous window is scaled while the next one multiplies.
               prod_ff <= mul_prod;
               unique case (mean_idx_ff)
                  MSEL_SHORT: begin
                     mean_idx_ff <= MSEL_MID;
                  end
                  MSEL_MID: begin
                     mean_short_ff <= LOAD_W'(prod_ff >> SHIFT_SHORT);
                     mean_idx_ff   <= MSEL_LONG;
                  end
                  MSEL_LONG: begin
                     mean_mid_ff <= LOAD_W'(prod_ff >> SHIFT_MID);
                     mean_idx_ff <= MSEL_END;
                  end
                  MSEL_END: begin
                     mean_long_ff <= LOAD_W'(prod_ff >> SHIFT_LONG);
                     state_ff     <= S_DONE;
                  end
               endcase
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_load_ff      <= load_ff;
                  rsp_load_vld_ff  <= load_vld_ff;
                  rsp_short_ff     <= vld_short ? mean_short_ff : '0;
                  rsp_short_vld_ff <= vld_short;
                  rsp_mid_ff       <= vld_mid ? mean_mid_ff : '0;
                  rsp_mid_vld_ff   <= vld_mid;
                  rsp_long_ff      <= vld_long ? mean_long_ff : '0;
                  rsp_long_vld_ff  <= vld_long;
                  state_ff         <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ch.ready            = (state_ff == S_IDLE);
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.load_now         = rsp_load_ff;
   assign rsp_ch.load_now_valid   = rsp_load_vld_ff;
   assign rsp_ch.mean_short       = rsp_short_ff;
   assign rsp_ch.mean_short_valid = rsp_short_vld_ff;
   assign rsp_ch.mean_mid         = rsp_mid_ff;
   assign rsp_ch.mean_mid_valid   = rsp_mid_vld_ff;
   assign rsp_ch.mean_long        = rsp_long_ff;
   assign rsp_ch.mean_long_valid  = rsp_long_vld_ff;

   `CLMA_ASSERT(a_load_range,
                rsp_valid_ff |-> rsp_load_ff <= LOAD_FULL_SCALE,
                "load above full scale")
   `CLMA_ASSERT(a_stored_bound,
                stored_cnt_ff <= CNT_W'(LONG_WINDOW),
                "stored count past ring depth")
   `CLMA_ASSERT(a_digit_bound,
                state_ff == S_DIGIT |-> digit_ff < DIGIT_W'(RADIX),
                "quotient digit overflow")
   `CLMA_ASSERT(a_mean_needs_load,
                rsp_valid_ff && (rsp_short_vld_ff || rsp_mid_vld_ff || rsp_long_vld_ff)
                   |-> rsp_load_vld_ff,
                "valid mean without a load")
   `CLMA_ASSERT_NEXT(a_accept_busy,
                     req_ch.valid && req_ch.ready,
                     state_ff != S_IDLE,
                     "accepted item left the sequencer idle")

endmodule

`default_nettype wire
